// ===== sv/ppgc_pkg.sv =====
// Shared widths, codes, hash constants and chunk size tables for the pattern engine.
package ppgc_pkg;

	// Field widths
	localparam int unsigned OFF_W      = 21;
	localparam int unsigned LEN_W      = 22;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 22;

	localparam int unsigned TABLE_ROWS = 11;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PACKET_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = 2'd2;

	// Hash constants; only the low 24 bits reach the folded output byte
	localparam logic [31:0] OFF_MUL  = 32'h045d9f3b;
	localparam logic [31:0] IDX_MUL  = 32'h27d4eb2d;
	localparam logic [31:0] FLOW_MUL = 32'h165667b1;
	localparam logic [31:0] RSP_SALT = 32'hA5A5A5A5;
	localparam logic [31:0] REQ_SALT = 32'h5A5A5A5A;

	// Flow marker masks for byte 0 of chunk 0
	localparam logic [7:0] RSP_MARK = 8'hC3;
	localparam logic [7:0] REQ_MARK = 8'h3C;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [IDX_W-1:0] idx;
		logic [7:0]       flow;
		logic             dir;
	} hash_key_t;

	function automatic logic [LEN_W-1:0] stream_size(input logic [IDX_W-1:0] idx);
		logic [LEN_W-1:0] s;
		case (idx)
			4'd0:    s = 22'd1;
			4'd1:    s = 22'd2;
			4'd2:    s = 22'd4;
			4'd3:    s = 22'd32;
			4'd4:    s = 22'd512;
			4'd5:    s = 22'd1024;
			4'd6:    s = 22'd4096;
			4'd7:    s = 22'd32768;
			4'd8:    s = 22'd32769;
			4'd9:    s = 22'd1048576;
			4'd10:   s = 22'd2097152;
			default: s = '0;
		endcase
		return s;
	endfunction

	function automatic logic [LEN_W-1:0] packet_size(input logic [IDX_W-1:0] idx,
			input logic [15:0] max_len);
		logic [LEN_W-1:0] s;
		case (idx)
			4'd0:    s = 22'd1;
			4'd1:    s = 22'd2;
			4'd2:    s = 22'd4;
			4'd3:    s = 22'd32;
			4'd4:    s = 22'd64;
			4'd5:    s = 22'd128;
			4'd6:    s = 22'd256;
			4'd7:    s = 22'd512;
			4'd8:    s = 22'd1024;
			4'd9:    s = {6'd0, max_len - 16'd1};
			4'd10:   s = {6'd0, max_len};
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

// ===== sv/ppgc_ifs.sv =====
// Handshake channel interfaces: byte requests, results and configuration writes.
interface ppgc_req_if import ppgc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             req_type;
	logic             direction;
	logic [IDX_W-1:0] chunk_id;
	logic [OFF_W-1:0] byte_offset;
	logic [7:0]       data_byte;
	logic             last_byte;

	modport source (output valid, req_type, direction, chunk_id, byte_offset,
		data_byte, last_byte, input ready);
	modport sink (input valid, req_type, direction, chunk_id, byte_offset,
		data_byte, last_byte, output ready);
endinterface

interface ppgc_rsp_if import ppgc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [7:0]       pattern_byte;
	logic [7:0]       actual_byte;
	logic             byte_mismatch;
	logic             chunk_done;
	logic             chunk_ok;
	logic [LEN_W-1:0] fail_offset;
	logic             index_error;

	modport source (output valid, pattern_byte, actual_byte, byte_mismatch, chunk_done,
		chunk_ok, fail_offset, index_error, input ready);
	modport sink (input valid, pattern_byte, actual_byte, byte_mismatch, chunk_done,
		chunk_ok, fail_offset, index_error, output ready);
endinterface

interface ppgc_cfg_if import ppgc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/ppgc_hash.sv =====
// Multiply-xor hash of offset, chunk, flow and direction, folded to one byte.
module ppgc_hash import ppgc_pkg::*; (
	input  hash_key_t  key,
	output logic [7:0] hash_byte
);

	logic [OFF_W-1:0]   mixed_off;
	logic [OFF_W+23:0]  off_prod;
	logic [IDX_W:0]     idx_inc;
	logic [IDX_W+24:0]  idx_prod;
	logic [8:0]         flow_inc;
	logic [32:0]        flow_prod;
	logic [23:0]        v;

	// Bits above 23 never reach the folded byte, so keep 24-bit products
	assign mixed_off = key.off ^ (key.off >> 13);
	assign off_prod  = {24'd0, mixed_off} * {{OFF_W{1'b0}}, OFF_MUL[23:0]};
	assign idx_inc   = {1'b0, key.idx} + {{IDX_W{1'b0}}, 1'b1};
	assign idx_prod  = {24'd0, idx_inc} * {{(IDX_W+1){1'b0}}, IDX_MUL[23:0]};
	assign flow_inc  = {1'b0, key.flow} + 9'd1;
	assign flow_prod = {24'd0, flow_inc} * {9'd0, FLOW_MUL[23:0]};

	assign v = off_prod[23:0] ^ idx_prod[23:0] ^ flow_prod[23:0]
		^ (key.dir ? RSP_SALT[23:0] : REQ_SALT[23:0]);

	assign hash_byte = v[7:0] ^ v[23:16];

endmodule

// ===== sv/payload_pattern_gen_check_top.sv =====
// Top level of the payload pattern generator and checker.
//
//   channel  modport  role
//   -------  -------  -------------------------------------------------------
//   req      sink     one payload byte to generate or check per beat
//   rsp      source   one result per request beat, in order
//   cfg      sink     register write: index and data, always ready
//
// Each byte passes from its request beat to its result beat through an input stage
// (_s1) and a result register (_s2), with the hash and the compare between them.
// One beat is taken per cycle; only a stalled result slows the request side.
// A stalled result holds in _s2 while the next byte waits in _s1.
// Reset sets the registers to their defaults and clears learned flow and verdict.
module payload_pattern_gen_check_top import ppgc_pkg::*; #(
	parameter int unsigned MAX_PACKET_LEN = 1500,
	parameter int unsigned CHUNK_SLOTS    = 11
) (
	input  logic      clk,
	input  logic      arst_n,
	ppgc_req_if.sink   req,
	ppgc_rsp_if.source rsp,
	ppgc_cfg_if.sink   cfg
);

	// Usable chunk slots: no more than the slot count or the table rows
	localparam logic [IDX_W-1:0] SLOTS_EFF =
		IDX_W'((CHUNK_SLOTS < TABLE_ROWS) ? CHUNK_SLOTS : TABLE_ROWS);
	localparam logic [15:0] MAX_LEN = 16'(MAX_PACKET_LEN);

	// Configuration registers
	logic             packet_mode_q;
	logic [LEN_W-1:0] max_payload_q;
	logic [IDX_W-1:0] chunk_count_q;

	// Checker state
	logic [7:0]       learned_flow_q;
	logic             chunk_failed_q;
	logic [LEN_W-1:0] first_bad_q;

	// Input stage
	logic             valid_s1;
	logic             req_type_s1;
	logic             direction_s1;
	logic [IDX_W-1:0] chunk_id_s1;
	logic [OFF_W-1:0] byte_offset_s1;
	logic [7:0]       data_byte_s1;
	logic             last_byte_s1;

	// Result register
	logic             valid_s2;
	logic [7:0]       pattern_byte_s2;
	logic [7:0]       actual_byte_s2;
	logic             byte_mismatch_s2;
	logic             chunk_done_s2;
	logic             chunk_ok_s2;
	logic [LEN_W-1:0] fail_offset_s2;
	logic             index_error_s2;

	logic             advance;
	logic [IDX_W-1:0] active_chunks;
	logic             ierr;
	logic             learning;
	logic             is_marker;
	logic             is_start;
	logic [7:0]       marker_flow;
	logic [7:0]       hash_byte;
	logic [7:0]       pat;
	logic             mism;
	logic             failed_eff;
	logic [LEN_W-1:0] first_eff;
	logic             failed_nxt;
	logic [LEN_W-1:0] first_nxt;
	logic [LEN_W-1:0] pkt_len;
	logic [LEN_W-1:0] exp_len;
	logic [LEN_W-1:0] rx_len;
	logic             ok;
	logic [LEN_W-1:0] bad;
	hash_key_t        key;

	// ---------------------------------------------------------------------
	// Configuration port: accept every write; ignore indexes beyond the list
	// ---------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_mode_q <= 1'b0;
			max_payload_q <= '0;
			chunk_count_q <= IDX_W'(TABLE_ROWS);
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_PACKET_MODE: packet_mode_q <= cfg.data[0];
				CFG_MAX_PAYLOAD: max_payload_q <= cfg.data[LEN_W-1:0];
				CFG_CHUNK_COUNT: chunk_count_q <= cfg.data[IDX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Handshake: advance _s1 into _s2 whenever _s2 is empty or being drained;
	// take a new beat whenever _s1 is empty or moving on this cycle
	// ---------------------------------------------------------------------
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1    <= req.req_type;
			direction_s1   <= req.direction;
			chunk_id_s1    <= req.chunk_id;
			byte_offset_s1 <= req.byte_offset;
			data_byte_s1   <= req.data_byte;
			last_byte_s1   <= req.last_byte;
		end
	end

	// ---------------------------------------------------------------------
	// Per-byte work
	// ---------------------------------------------------------------------
	assign active_chunks = (chunk_count_q > SLOTS_EFF) ? SLOTS_EFF : chunk_count_q;
	assign ierr          = (chunk_id_s1 >= active_chunks);
	assign is_start      = (byte_offset_s1 == '0);
	assign is_marker     = (chunk_id_s1 == '0) && is_start;

	// In-range request chunk 0 on a check teaches the flow id rather than being compared
	assign learning = req_type_s1 && !direction_s1 && (chunk_id_s1 == '0) && !ierr;

	assign key.off  = byte_offset_s1;
	assign key.idx  = chunk_id_s1;
	assign key.flow = learned_flow_q;
	assign key.dir  = direction_s1;

	ppgc_hash u_hash (
		.key       (key),
		.hash_byte (hash_byte)
	);

	// The marker byte sees a flow learned from this very byte
	assign marker_flow = learning ? (data_byte_s1 ^ REQ_MARK) : learned_flow_q;
	assign pat = is_marker ? (marker_flow ^ (direction_s1 ? RSP_MARK : REQ_MARK))
		: hash_byte;

	assign mism = req_type_s1 && !learning && (data_byte_s1 != pat);

	// Offset zero opens a fresh chunk verdict before the compare
	assign failed_eff = is_start ? 1'b0 : chunk_failed_q;
	assign first_eff  = is_start ? '0 : first_bad_q;
	assign failed_nxt = failed_eff || mism;
	assign first_nxt  = (mism && !failed_eff) ? {1'b0, byte_offset_s1} : first_eff;

	// Expected length; clamp packet sizes by a nonzero payload limit
	assign pkt_len = packet_size(chunk_id_s1, MAX_LEN);
	always_comb begin
		if (!packet_mode_q) begin
			exp_len = stream_size(chunk_id_s1);
		end else if ((max_payload_q != '0) && (pkt_len > max_payload_q)) begin
			exp_len = max_payload_q;
		end else begin
			exp_len = pkt_len;
		end
	end

	assign rx_len = {1'b0, byte_offset_s1} + {{(LEN_W-1){1'b0}}, 1'b1};

	// Verdict: a wrong length or a bad index wins, then the learning pass, then
	// the first mismatching offset
	always_comb begin
		ok  = 1'b1;
		bad = '0;
		if (ierr || (rx_len != exp_len)) begin
			ok  = 1'b0;
			bad = rx_len;
		end else if (learning) begin
			ok = 1'b1;
		end else if (failed_nxt) begin
			ok  = 1'b0;
			bad = first_nxt;
		end
	end

	// ---------------------------------------------------------------------
	// State update: only checked bytes touch it, on the cycle they advance
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learned_flow_q <= '0;
			chunk_failed_q <= 1'b0;
			first_bad_q    <= '0;
		end else if (advance && req_type_s1) begin
			if (learning && is_start) begin
				learned_flow_q <= data_byte_s1 ^ REQ_MARK;
			end
			if (last_byte_s1) begin
				chunk_failed_q <= 1'b0;
				first_bad_q    <= '0;
			end else begin
				chunk_failed_q <= failed_nxt;
				first_bad_q    <= first_nxt;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pattern_byte_s2  <= pat;
			actual_byte_s2   <= req_type_s1 ? data_byte_s1 : 8'd0;
			byte_mismatch_s2 <= mism;
			chunk_done_s2    <= req_type_s1 && last_byte_s1;
			chunk_ok_s2      <= req_type_s1 && last_byte_s1 && ok;
			fail_offset_s2   <= (req_type_s1 && last_byte_s1) ? bad : '0;
			index_error_s2   <= ierr;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.pattern_byte  = pattern_byte_s2;
	assign rsp.actual_byte   = actual_byte_s2;
	assign rsp.byte_mismatch = byte_mismatch_s2;
	assign rsp.chunk_done    = chunk_done_s2;
	assign rsp.chunk_ok      = chunk_ok_s2;
	assign rsp.fail_offset   = fail_offset_s2;
	assign rsp.index_error   = index_error_s2;

`ifndef NO_ASSERTIONS
	// A closed chunk leaves no verdict behind for the next one
	a_verdict_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_type_s1 && last_byte_s1 |=> !chunk_failed_q && (first_bad_q == '0))
		else $error("chunk verdict not cleared after last byte");

	// A pass is only ever reported at the end of a chunk
	a_ok_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.chunk_ok |-> rsp.chunk_done)
		else $error("chunk_ok without chunk_done");

	// A mismatch on the closing byte cannot pass
	a_mism_fails: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.chunk_done && rsp.byte_mismatch |-> !rsp.chunk_ok)
		else $error("chunk passed with a mismatching last byte");

	// A bad index reports the received length as a failure
	a_ierr_fails: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.chunk_done && rsp.index_error |-> !rsp.chunk_ok
			&& (rsp.fail_offset != '0))
		else $error("index error not reported as a failure");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the payload pattern engine: predicted results, random idling.
module testbench import ppgc_pkg::*; ();

	// Keep these in step with the parameters handed to the block below
	localparam int unsigned PKT_MAX_LEN  = 1500;
	localparam int unsigned SLOTS        = 11;
	// Receiver hold-off for the back-pressure phase, in cycles
	localparam int unsigned HOLD_LEN     = 400;
	// Cycles without a single beat before the run is declared hung
	localparam int unsigned STALL_LIMIT  = 3000;
	// Settle time after the last result; the block answers from its result register
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned MAX_PRINTS   = 40;
	localparam logic [OFF_W-1:0] OFF_MAX = '1;

	typedef enum logic {GEN_BYTE = 1'b0, CHECK_BYTE = 1'b1} req_kind_t;
	typedef enum logic {DIR_REQUEST = 1'b0, DIR_RESPONSE = 1'b1} dir_t;

	typedef struct packed {
		req_kind_t        req_type;
		dir_t             direction;
		logic [IDX_W-1:0] chunk_id;
		logic [OFF_W-1:0] byte_offset;
		logic [7:0]       data_byte;
		logic             last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [7:0]       pattern_byte;
		logic [7:0]       actual_byte;
		logic             byte_mismatch;
		logic             chunk_done;
		logic             chunk_ok;
		logic [LEN_W-1:0] fail_offset;
		logic             index_error;
	} verdict_t;

	logic clk;
	logic arst_n;

	ppgc_req_if req_ch ();
	ppgc_rsp_if rsp_ch ();
	ppgc_cfg_if cfg_ch ();

	payload_pattern_gen_check_top #(
		.MAX_PACKET_LEN (PKT_MAX_LEN),
		.CHUNK_SLOTS    (SLOTS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Register copies, shared by the stimulus builder and the predictor. They
	// only change while the block is drained, so both sides always agree.
	logic             cfg_pkt;
	logic [LEN_W-1:0] cfg_maxpl;
	logic [3:0]       cfg_chunks;

	// Predictor state: flow id learnt so far and the verdict of the open chunk
	logic [7:0]       flow_seen;
	logic             chunk_bad;
	logic [LEN_W-1:0] first_bad_off;

	// Flow id as the stimulus builder expects it once queued beats are applied
	logic [7:0]       gen_flow;

	byte_item_t pending_bytes[$];
	verdict_t   due_results[$];

	int   send_idle_pct;
	int   stall_pct;
	int   errors;
	int   queued;
	int   idle_cycles;
	int   hold_left;
	logic req_took;
	logic hold_go;
	logic hold_seen;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Chunks in use: the register, capped by the slots and the table depth
	function automatic int unsigned active_chunks();
		int unsigned n = cfg_chunks;
		if (n > SLOTS)
			n = SLOTS;
		if (n > TABLE_ROWS)
			n = TABLE_ROWS;
		return n;
	endfunction

	// Expected chunk length; rows past the table give zero
	function automatic logic [LEN_W-1:0] chunk_len(input logic [IDX_W-1:0] idx);
		int unsigned s;
		s = 0;
		if (!cfg_pkt) begin
			case (idx)
				4'd0:  s = 1;
				4'd1:  s = 2;
				4'd2:  s = 4;
				4'd3:  s = 32;
				4'd4:  s = 512;
				4'd5:  s = 1024;
				4'd6:  s = 4096;
				4'd7:  s = 32768;
				4'd8:  s = 32769;
				4'd9:  s = 1024 * 1024;
				4'd10: s = 2 * 1024 * 1024;
				default: s = 0;
			endcase
		end else begin
			case (idx)
				4'd0:  s = 1;
				4'd1:  s = 2;
				4'd2:  s = 4;
				4'd3:  s = 32;
				4'd4:  s = 64;
				4'd5:  s = 128;
				4'd6:  s = 256;
				4'd7:  s = 512;
				4'd8:  s = 1024;
				4'd9:  s = PKT_MAX_LEN - 1;
				4'd10: s = PKT_MAX_LEN;
				default: s = 0;
			endcase
			// Clamp to the payload limit; zero leaves the table value alone
			if (cfg_maxpl != 0 && s > cfg_maxpl)
				s = cfg_maxpl;
		end
		return LEN_W'(s);
	endfunction

	// Pattern byte: flow marker at the head of chunk 0, else the low byte of the hash
	function automatic logic [7:0] pattern_of(input logic [OFF_W-1:0] off,
			input logic [IDX_W-1:0] idx, input logic [7:0] flow, input logic dir);
		logic [31:0] v;
		if (idx == 0 && off == 0)
			return flow ^ (dir ? RSP_MARK : REQ_MARK);
		v = 32'(off);
		v = v ^ (v >> 13);
		v = v * OFF_MUL;
		v = v ^ ((32'(idx) + 32'd1) * IDX_MUL);
		v = v ^ ((32'(flow) + 32'd1) * FLOW_MUL);
		v = v ^ (dir ? RSP_SALT : REQ_SALT);
		v = v ^ (v >> 16);
		return v[7:0];
	endfunction

	// Work out the result of one accepted beat and advance the predictor state
	function automatic verdict_t predict_byte(input byte_item_t b);
		verdict_t         r;
		logic             learning;
		logic [LEN_W-1:0] rcvd_len;
		r = '0;
		r.index_error = (b.chunk_id >= active_chunks());
		if (b.req_type == GEN_BYTE) begin
			// Generating leaves every piece of state untouched
			r.pattern_byte = pattern_of(b.byte_offset, b.chunk_id, flow_seen, b.direction);
			return r;
		end
		r.actual_byte = b.data_byte;
		// Offset zero opens a new chunk: drop any verdict carried over
		if (b.byte_offset == 0) begin
			chunk_bad     = 1'b0;
			first_bad_off = '0;
		end
		// In-range request chunk 0 teaches the flow id and is never compared
		learning = (b.direction == DIR_REQUEST) && (b.chunk_id == 0) && !r.index_error;
		if (learning && b.byte_offset == 0)
			flow_seen = b.data_byte ^ REQ_MARK;
		r.pattern_byte = pattern_of(b.byte_offset, b.chunk_id, flow_seen, b.direction);
		if (!learning) begin
			r.byte_mismatch = (b.data_byte != r.pattern_byte);
			if (r.byte_mismatch && !chunk_bad) begin
				chunk_bad     = 1'b1;
				first_bad_off = LEN_W'(b.byte_offset);
			end
		end
		if (b.last_byte) begin
			// Length comes from the last offset alone; gaps are not looked at
			rcvd_len     = LEN_W'(b.byte_offset) + 1'b1;
			r.chunk_done = 1'b1;
			if (r.index_error || rcvd_len != chunk_len(b.chunk_id))
				r.fail_offset = rcvd_len;
			else if (learning || !chunk_bad)
				r.chunk_ok = 1'b1;
			else
				r.fail_offset = first_bad_off;
			chunk_bad     = 1'b0;
			first_bad_off = '0;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_error(input string msg);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
	endtask

	// ------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------

	// Append a beat and follow any flow id it will teach the block
	task automatic queue_byte(input byte_item_t b);
		if (b.req_type == CHECK_BYTE && b.direction == DIR_REQUEST && b.chunk_id == 0
				&& b.byte_offset == 0 && b.chunk_id < active_chunks())
			gen_flow = b.data_byte ^ REQ_MARK;
		pending_bytes.push_back(b);
		queued++;
	endtask

	// Build a beat whose data matches the pattern unless it is to be spoilt
	task automatic add_byte(input req_kind_t kind, input dir_t dir,
			input logic [IDX_W-1:0] idx, input logic [OFF_W-1:0] off,
			input logic last, input logic corrupt);
		byte_item_t b;
		logic [7:0] pat;
		b.req_type    = kind;
		b.direction   = dir;
		b.chunk_id    = idx;
		b.byte_offset = off;
		b.last_byte   = last;
		pat = pattern_of(off, idx, gen_flow, dir);
		// Data is ignored when generating and not compared on in-range request chunk 0: make it random
		if (kind == GEN_BYTE || (dir == DIR_REQUEST && idx == 0 && idx < active_chunks()))
			b.data_byte = 8'($urandom);
		else if (corrupt)
			b.data_byte = pat ^ 8'($urandom_range(255, 1));
		else
			b.data_byte = pat;
		queue_byte(b);
	endtask

	// One received chunk: its head, a jump to the tail of a long one, and now and then a fault
	task automatic queue_chunk();
		int          offs[$];
		int unsigned s;
		int unsigned hk;
		int unsigned tk;
		int unsigned act;
		int          fault;
		int          bad_at;
		logic [IDX_W-1:0] idx;
		dir_t        dir;
		act = active_chunks();
		dir = dir_t'($urandom_range(1));
		if (act > 0 && $urandom_range(99) < 85)
			idx = IDX_W'($urandom_range(act - 1));
		else
			idx = IDX_W'($urandom_range(15));
		s = chunk_len(idx);
		if (s == 0)
			s = $urandom_range(6, 1);
		if (s <= 8) begin
			for (int o = 0; o < s; o++)
				offs.push_back(o);
		end else begin
			// Offsets need not be contiguous, so long chunks skip to their tail
			hk = $urandom_range(4, 1);
			tk = $urandom_range(3, 1);
			for (int o = 0; o < hk; o++)
				offs.push_back(o);
			for (int o = s - tk; o < s; o++)
				offs.push_back(o);
		end
		fault = $urandom_range(99);
		if (fault < 10 && offs.size() > 1)
			void'(offs.pop_back());        // end short
		else if (fault < 18 && s <= OFF_MAX)
			offs.push_back(s);             // run one byte long
		else if (fault < 22 && offs.size() > 1)
			void'(offs.pop_front());       // lose the chunk opening
		bad_at = ($urandom_range(99) < 15) ? $urandom_range(offs.size() - 1) : -1;
		foreach (offs[i])
			add_byte(CHECK_BYTE, dir, idx, OFF_W'(offs[i]), i == offs.size() - 1, i == bad_at);
	endtask

	// Mostly well-formed chunks, with bursts of generate beats and raw noise
	task automatic fill_random(input int n);
		int         goal;
		int         pick;
		int         k;
		byte_item_t b;
		goal = queued + n;
		while (queued < goal) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				b.req_type    = req_kind_t'($urandom_range(1));
				b.direction   = dir_t'($urandom_range(1));
				b.chunk_id    = IDX_W'($urandom_range(15));
				b.byte_offset = OFF_W'($urandom);
				b.data_byte   = 8'($urandom);
				b.last_byte   = 1'($urandom_range(1));
				queue_byte(b);
			end else if (pick < 22) begin
				k = $urandom_range(4, 1);
				repeat (k)
					add_byte(GEN_BYTE, dir_t'($urandom_range(1)), IDX_W'($urandom_range(15)),
						$urandom_range(1) ? OFF_W'($urandom_range(3)) : OFF_W'($urandom),
						1'($urandom_range(1)), 1'b0);
			end else begin
				queue_chunk();
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Configuration and phases
	// ------------------------------------------------------------------

	// Write one register; the copy follows at the beat itself
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		cfg_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		case (idx)
			CFG_PACKET_MODE: cfg_pkt    = val[0];
			CFG_MAX_PAYLOAD: cfg_maxpl  = val;
			CFG_CHUNK_COUNT: cfg_chunks = val[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Hold until every queued beat has gone in and every result has come back
	task automatic wait_drained();
		while (pending_bytes.size() > 0 || req_ch.valid || due_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Drain, rewrite all three registers, then set the idling of both sides
	task automatic start_phase(input logic pm, input logic [CFG_DATA_W-1:0] mp,
			input logic [3:0] cc, input int sidle, input int rstall);
		wait_drained();
		write_reg(CFG_PACKET_MODE, CFG_DATA_W'(pm));
		write_reg(CFG_MAX_PAYLOAD, mp);
		write_reg(CFG_CHUNK_COUNT, CFG_DATA_W'(cc));
		@(posedge clk);
		send_idle_pct = sidle;
		stall_pct     = rstall;
	endtask

	// ------------------------------------------------------------------
	// Request driver: a new beat goes out at the falling edge once the
	// previous one was taken, or after an idle cycle
	// ------------------------------------------------------------------
	always @(negedge clk) begin : drive_bytes
		byte_item_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_took) begin
			if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_bytes.pop_front();
				req_ch.req_type    <= nxt.req_type;
				req_ch.direction   <= nxt.direction;
				req_ch.chunk_id    <= nxt.chunk_id;
				req_ch.byte_offset <= nxt.byte_offset;
				req_ch.data_byte   <= nxt.data_byte;
				req_ch.last_byte   <= nxt.last_byte;
				req_ch.valid       <= 1'b1;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result ready: random stalls, plus one long hold-off on request so that
	// the pipeline fills and pushes back on the request channel
	// ------------------------------------------------------------------
	always @(negedge clk) begin : drive_ready
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_seen    <= 1'b0;
			hold_left    <= 0;
		end else if (hold_seen != hold_go) begin
			hold_seen    <= hold_go;
			hold_left    <= HOLD_LEN;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on every request beat, compare on every result beat
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch_beats
		byte_item_t b;
		verdict_t   want;
		verdict_t   got;
		if (!arst_n) begin
			req_took <= 1'b0;
		end else begin
			req_took <= req_ch.valid && req_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				b.req_type    = req_kind_t'(req_ch.req_type);
				b.direction   = dir_t'(req_ch.direction);
				b.chunk_id    = req_ch.chunk_id;
				b.byte_offset = req_ch.byte_offset;
				b.data_byte   = req_ch.data_byte;
				b.last_byte   = req_ch.last_byte;
				due_results.push_back(predict_byte(b));
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.pattern_byte  = rsp_ch.pattern_byte;
				got.actual_byte   = rsp_ch.actual_byte;
				got.byte_mismatch = rsp_ch.byte_mismatch;
				got.chunk_done    = rsp_ch.chunk_done;
				got.chunk_ok      = rsp_ch.chunk_ok;
				got.fail_offset   = rsp_ch.fail_offset;
				got.index_error   = rsp_ch.index_error;
				if (due_results.size() == 0) begin
					report_error("result beat with no byte outstanding");
				end else begin
					want = due_results.pop_front();
					check_field("pattern_byte", got.pattern_byte, want.pattern_byte);
					check_field("actual_byte", got.actual_byte, want.actual_byte);
					check_field("byte_mismatch", got.byte_mismatch, want.byte_mismatch);
					check_field("chunk_done", got.chunk_done, want.chunk_done);
					check_field("chunk_ok", got.chunk_ok, want.chunk_ok);
					check_field("fail_offset", got.fail_offset, want.fail_offset);
					check_field("index_error", got.index_error, want.index_error);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any beat on any channel counts as progress
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watchdog
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat for %0d cycles", idle_cycles);
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : run_test
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.req_type    = 1'b0;
		req_ch.direction   = 1'b0;
		req_ch.chunk_id    = '0;
		req_ch.byte_offset = '0;
		req_ch.data_byte   = '0;
		req_ch.last_byte   = 1'b0;
		rsp_ch.ready       = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = CFG_PACKET_MODE;
		cfg_ch.data        = '0;
		hold_go            = 1'b0;
		send_idle_pct      = 0;
		stall_pct          = 0;
		errors             = 0;
		queued             = 0;
		gen_flow           = '0;
		flow_seen          = '0;
		chunk_bad          = 1'b0;
		first_bad_off      = '0;
		cfg_pkt            = 1'b0;
		cfg_maxpl          = '0;
		cfg_chunks         = 4'd11;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Stream sizes, all chunks in use, no idling: directed cases first
		start_phase(1'b0, '0, 4'd11, 0, 0);
		add_byte(GEN_BYTE, DIR_REQUEST, 4'd0, '0, 1'b0, 1'b0);         // marker, flow zero
		add_byte(GEN_BYTE, DIR_RESPONSE, 4'd0, '0, 1'b1, 1'b0);
		add_byte(CHECK_BYTE, DIR_REQUEST, 4'd0, '0, 1'b1, 1'b0);       // learn the flow
		add_byte(GEN_BYTE, DIR_RESPONSE, 4'd0, '0, 1'b0, 1'b0);        // marker, new flow
		add_byte(CHECK_BYTE, DIR_RESPONSE, 4'd0, '0, 1'b1, 1'b0);      // marker passes
		add_byte(CHECK_BYTE, DIR_RESPONSE, 4'd0, '0, 1'b1, 1'b1);      // marker fails
		add_byte(CHECK_BYTE, DIR_REQUEST, 4'd1, 21'd0, 1'b0, 1'b0);    // clean two-byte chunk
		add_byte(CHECK_BYTE, DIR_REQUEST, 4'd1, 21'd1, 1'b1, 1'b0);
		add_byte(CHECK_BYTE, DIR_RESPONSE, 4'd2, 21'd0, 1'b0, 1'b0);   // first bad offset wins
		add_byte(CHECK_BYTE, DIR_RESPONSE, 4'd2, 21'd1, 1'b0, 1'b1);
		add_byte(CHECK_BYTE, DIR_RESPONSE, 4'd2, 21'd2, 1'b0, 1'b1);
		add_byte(CHECK_BYTE, DIR_RESPONSE, 4'd2, 21'd3, 1'b1, 1'b0);
		add_byte(CHECK_BYTE, DIR_REQUEST, 4'd3, 21'd0, 1'b1, 1'b0);    // too short
		add_byte(CHECK_BYTE, DIR_REQUEST, 4'd10, OFF_MAX, 1'b1, 1'b0); // largest chunk ends
		add_byte(GEN_BYTE, DIR_RESPONSE, 4'd15, OFF_MAX, 1'b1, 1'b0);  // index out of range
		add_byte(CHECK_BYTE, DIR_RESPONSE, 4'd11, 21'd0, 1'b1, 1'b0);  // index error verdict
		add_byte(CHECK_BYTE, DIR_REQUEST, 4'd0, 21'd5, 1'b1, 1'b0);    // learning chunk, wrong length
		add_byte(CHECK_BYTE, DIR_REQUEST, 4'd0, 21'd0, 1'b0, 1'b0);    // learn, chunk left open
		add_byte(CHECK_BYTE, DIR_RESPONSE, 4'd4, 21'd0, 1'b0, 1'b1);   // bad, then reopened
		add_byte(CHECK_BYTE, DIR_RESPONSE, 4'd4, 21'd0, 1'b0, 1'b0);
		add_byte(CHECK_BYTE, DIR_RESPONSE, 4'd4, 21'd511, 1'b1, 1'b0);
		add_byte(CHECK_BYTE, DIR_REQUEST, 4'd9, 21'd1048575, 1'b1, 1'b1);
		add_byte(CHECK_BYTE, DIR_RESPONSE, 4'd8, 21'd32768, 1'b1, 1'b0);
		fill_random(300);

		// Packet sizes without a clamp; the sender idles
		start_phase(1'b1, '0, 4'd11, 55, 0);
		fill_random(250);

		// Tight clamp, fewer chunks; the receiver stalls
		start_phase(1'b1, CFG_DATA_W'(100), 4'd7, 0, 55);
		fill_random(250);

		// Largest clamp and chunk count beyond the slots; both sides idle
		start_phase(1'b1, '1, 4'd15, 36, 36);
		fill_random(200);

		// Back-pressure: hold the result side off while the sender keeps offering
		start_phase(1'b0, CFG_DATA_W'(1), 4'd3, 0, 0);
		hold_go = ~hold_go;
		fill_random(150);

		// No chunks in use: every index is an error
		start_phase(1'b1, CFG_DATA_W'(1), 4'd0, 36, 36);
		fill_random(100);

		// Clamp just below the packet maximum
		start_phase(1'b1, CFG_DATA_W'(PKT_MAX_LEN - 1), 4'd11, 0, 0);
		fill_random(100);

		// Let the last results land and give any stray beat time to show up
		wait_drained();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
